[sv/ghdc_pkg.sv]
// ----------------------------------------------------------------------------
// Gyro heading duty corrector package
// Shared widths, command and mode codes, stage control type and the
// correction step ladder.
// ----------------------------------------------------------------------------
package ghdc_pkg;

    // Parameter defaults
    localparam int DUTY_BITS_DEF  = 13;
    localparam int COUNT_BITS_DEF = 10;
    localparam int TICK_MS_DEF    = 40;

    // Fixed field widths
    localparam int GYRO_W = 16;
    localparam int TIME_W = 32;
    localparam int THR_W  = 15;
    localparam int FUNC_W = 3;
    localparam int STEP_W = 8;
    localparam int DIFF_W = 16;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);

    // Correction ladder: count difference above a limit selects a step
    localparam logic [DIFF_W-1:0] DIFF_LIM_A = DIFF_W'(25);
    localparam logic [DIFF_W-1:0] DIFF_LIM_B = DIFF_W'(20);
    localparam logic [DIFF_W-1:0] DIFF_LIM_C = DIFF_W'(15);
    localparam logic [DIFF_W-1:0] DIFF_LIM_D = DIFF_W'(10);
    localparam logic [STEP_W-1:0] STEP_A     = STEP_W'(200);
    localparam logic [STEP_W-1:0] STEP_B     = STEP_W'(100);
    localparam logic [STEP_W-1:0] STEP_C     = STEP_W'(50);
    localparam logic [STEP_W-1:0] STEP_D     = STEP_W'(20);
    localparam logic [STEP_W-1:0] STEP_E     = STEP_W'(5);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE   = 3'd0,
        FUNC_TICK     = 3'd1,
        FUNC_STRAIGHT = 3'd2,
        FUNC_CW       = 3'd3,
        FUNC_ACW      = 3'd4,
        FUNC_STOP     = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_STRAIGHT = 2'd1,
        MODE_CW       = 2'd2,
        MODE_ACW      = 2'd3
    } mode_t;

    // Input stage status towards the core and the result stage
    typedef struct packed {
        logic fire;
    } stage_ctrl_t;

    // Pick the correction step from the turn count difference
    function automatic logic [STEP_W-1:0] step_sel(input logic [DIFF_W-1:0] diff);
        logic [STEP_W-1:0] step;
        if (diff > DIFF_LIM_A)
            step = STEP_A;
        else if (diff > DIFF_LIM_B)
            step = STEP_B;
        else if (diff > DIFF_LIM_C)
            step = STEP_C;
        else if (diff > DIFF_LIM_D)
            step = STEP_D;
        else
            step = STEP_E;
        return step;
    endfunction

endpackage

[sv/ghdc_in_stage.sv]
// ----------------------------------------------------------------------------
// Gyro heading duty corrector input stage
// Registers one request from the slave side and unpacks its fields.
// ----------------------------------------------------------------------------
module ghdc_in_stage #(
    parameter int DUTY_BITS = ghdc_pkg::DUTY_BITS_DEF,
    parameter int S_DATA_W  = ((ghdc_pkg::GYRO_W + DUTY_BITS + ghdc_pkg::TIME_W + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [S_DATA_W-1:0]              s_axis_tdata,
    input  logic [ghdc_pkg::FUNC_W-1:0]      s_axis_tuser,
    input  logic                             take,
    output ghdc_pkg::stage_ctrl_t            ctrl,
    output logic [ghdc_pkg::FUNC_W-1:0]      func,
    output logic signed [ghdc_pkg::GYRO_W-1:0] gyro_z,
    output logic [DUTY_BITS-1:0]             base_duty,
    output logic [ghdc_pkg::TIME_W-1:0]      run_time_ms
);

    localparam int DUTY_LO = ghdc_pkg::GYRO_W;
    localparam int TIME_LO = ghdc_pkg::GYRO_W + DUTY_BITS;

    logic                          valid_reg;
    logic [S_DATA_W-1:0]           data_reg;
    logic [ghdc_pkg::FUNC_W-1:0]   user_reg;
    logic                          accept;

    // Take a new request when empty or when the held one moves on
    assign s_axis_tready = !valid_reg || take;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ctrl.fire     = valid_reg && take;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= s_axis_tdata;
            user_reg <= s_axis_tuser;
        end
    end

    // Unpack fields, lowest first
    assign func        = user_reg;
    assign gyro_z      = data_reg[ghdc_pkg::GYRO_W-1:0];
    assign base_duty   = data_reg[DUTY_LO +: DUTY_BITS];
    assign run_time_ms = data_reg[TIME_LO +: ghdc_pkg::TIME_W];

endmodule

[sv/ghdc_core.sv]
// ----------------------------------------------------------------------------
// Gyro heading duty corrector core
// Holds the motion state and threshold register, and works out the next
// state and the reported duties for the request in the input stage.
// ----------------------------------------------------------------------------
module ghdc_core #(
    parameter int DUTY_BITS  = ghdc_pkg::DUTY_BITS_DEF,
    parameter int COUNT_BITS = ghdc_pkg::COUNT_BITS_DEF,
    parameter int TICK_MS    = ghdc_pkg::TICK_MS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [ghdc_pkg::THR_W-1:0]         cfg_data,
    input  ghdc_pkg::stage_ctrl_t              ctrl,
    input  logic [ghdc_pkg::FUNC_W-1:0]        func,
    input  logic signed [ghdc_pkg::GYRO_W-1:0] gyro_z,
    input  logic [DUTY_BITS-1:0]               base_duty,
    input  logic [ghdc_pkg::TIME_W-1:0]        run_time_ms,
    output logic [DUTY_BITS-1:0]               left_duty_out,
    output logic [DUTY_BITS-1:0]               right_duty_out,
    output logic                               moving
);

    localparam int CMP_W = ghdc_pkg::GYRO_W + 1;

    logic [ghdc_pkg::THR_W-1:0]  thr_reg;
    logic [DUTY_BITS-1:0]        left_duty_reg,  left_duty_next;
    logic [DUTY_BITS-1:0]        right_duty_reg, right_duty_next;
    logic [ghdc_pkg::TIME_W-1:0] time_left_reg,  time_left_next;
    ghdc_pkg::mode_t             mode_reg,       mode_next;
    logic [COUNT_BITS-1:0]       left_cnt_reg,   left_cnt_next;
    logic [COUNT_BITS-1:0]       right_cnt_reg,  right_cnt_next;

    logic signed [CMP_W-1:0]     gz_ext;
    logic signed [CMP_W-1:0]     thr_pos;
    logic signed [CMP_W-1:0]     thr_neg;
    logic [COUNT_BITS-1:0]       cnt_diff;
    logic [ghdc_pkg::STEP_W-1:0] step;
    logic                        time_runs_on;
    ghdc_pkg::func_t             cmd;

    // Saturating duty step up
    function automatic logic [DUTY_BITS-1:0] duty_up(input logic [DUTY_BITS-1:0] d,
                                                     input logic [ghdc_pkg::STEP_W-1:0] s);
        logic [DUTY_BITS:0] sum;
        sum = {1'b0, d} + (DUTY_BITS+1)'(s);
        return sum[DUTY_BITS] ? {DUTY_BITS{1'b1}} : sum[DUTY_BITS-1:0];
    endfunction

    // Duty step down, floored at zero
    function automatic logic [DUTY_BITS-1:0] duty_down(input logic [DUTY_BITS-1:0] d,
                                                       input logic [ghdc_pkg::STEP_W-1:0] s);
        logic [DUTY_BITS-1:0] sd;
        sd = DUTY_BITS'(s);
        return (d > sd) ? d - sd : '0;
    endfunction

    // Gyro against the threshold window
    assign gz_ext  = {gyro_z[ghdc_pkg::GYRO_W-1], gyro_z};
    assign thr_pos = signed'({2'b00, thr_reg});
    assign thr_neg = -thr_pos;

    // Turn count difference and step
    assign cnt_diff = (left_cnt_reg >= right_cnt_reg) ? left_cnt_reg - right_cnt_reg
                                                      : right_cnt_reg - left_cnt_reg;
    assign step     = ghdc_pkg::step_sel(ghdc_pkg::DIFF_W'(cnt_diff));

    // Open-ended run or time still above one tick
    assign time_runs_on = (time_left_reg == '0) ||
                          (time_left_reg > ghdc_pkg::TIME_W'(TICK_MS));

    assign cmd = ghdc_pkg::func_t'(func);

    // Next state for the held request
    always_comb
    begin
        mode_next       = mode_reg;
        left_duty_next  = left_duty_reg;
        right_duty_next = right_duty_reg;
        time_left_next  = time_left_reg;
        left_cnt_next   = left_cnt_reg;
        right_cnt_next  = right_cnt_reg;
        unique case (cmd) inside
            ghdc_pkg::FUNC_SAMPLE:
            begin
                if (mode_reg == ghdc_pkg::MODE_STRAIGHT)
                begin
                    if (gz_ext > thr_pos)
                    begin
                        if (right_cnt_reg != {COUNT_BITS{1'b1}})
                            right_cnt_next = right_cnt_reg + 1'b1;
                    end
                    else if (gz_ext < thr_neg)
                    begin
                        if (left_cnt_reg != {COUNT_BITS{1'b1}})
                            left_cnt_next = left_cnt_reg + 1'b1;
                    end
                end
            end
            ghdc_pkg::FUNC_TICK:
            begin
                if (mode_reg != ghdc_pkg::MODE_IDLE)
                begin
                    if (time_runs_on)
                    begin
                        if (time_left_reg != '0)
                            time_left_next = time_left_reg - ghdc_pkg::TIME_W'(TICK_MS);
                        if (mode_reg == ghdc_pkg::MODE_STRAIGHT)
                        begin
                            // Shift duties toward the slower side
                            if (left_cnt_reg > right_cnt_reg)
                            begin
                                left_duty_next  = duty_up(left_duty_reg, step);
                                right_duty_next = duty_down(right_duty_reg, step);
                            end
                            else if (left_cnt_reg < right_cnt_reg)
                            begin
                                left_duty_next  = duty_down(left_duty_reg, step);
                                right_duty_next = duty_up(right_duty_reg, step);
                            end
                            left_cnt_next  = '0;
                            right_cnt_next = '0;
                        end
                    end
                    else
                    begin
                        mode_next       = ghdc_pkg::MODE_IDLE;
                        left_duty_next  = '0;
                        right_duty_next = '0;
                        time_left_next  = '0;
                        left_cnt_next   = '0;
                        right_cnt_next  = '0;
                    end
                end
            end
            ghdc_pkg::FUNC_STRAIGHT, ghdc_pkg::FUNC_CW, ghdc_pkg::FUNC_ACW:
            begin
                if (cmd == ghdc_pkg::FUNC_STRAIGHT)
                    mode_next = ghdc_pkg::MODE_STRAIGHT;
                else if (cmd == ghdc_pkg::FUNC_CW)
                    mode_next = ghdc_pkg::MODE_CW;
                else
                    mode_next = ghdc_pkg::MODE_ACW;
                left_duty_next  = base_duty;
                right_duty_next = base_duty;
                time_left_next  = run_time_ms;
                left_cnt_next   = '0;
                right_cnt_next  = '0;
            end
            ghdc_pkg::FUNC_STOP:
            begin
                mode_next       = ghdc_pkg::MODE_IDLE;
                left_duty_next  = '0;
                right_duty_next = '0;
                time_left_next  = '0;
                left_cnt_next   = '0;
                right_cnt_next  = '0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Report duties from the state after the request
    always_comb
    begin
        left_duty_out  = '0;
        right_duty_out = '0;
        if (mode_next == ghdc_pkg::MODE_STRAIGHT || mode_next == ghdc_pkg::MODE_CW)
            left_duty_out = left_duty_next;
        if (mode_next == ghdc_pkg::MODE_STRAIGHT || mode_next == ghdc_pkg::MODE_ACW)
            right_duty_out = right_duty_next;
        moving = (mode_next != ghdc_pkg::MODE_IDLE);
    end

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= ghdc_pkg::THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // Advance the motion state when the request moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ghdc_pkg::MODE_IDLE;
            left_duty_reg  <= '0;
            right_duty_reg <= '0;
            time_left_reg  <= '0;
            left_cnt_reg   <= '0;
            right_cnt_reg  <= '0;
        end
        else if (ctrl.fire)
        begin
            mode_reg       <= mode_next;
            left_duty_reg  <= left_duty_next;
            right_duty_reg <= right_duty_next;
            time_left_reg  <= time_left_next;
            left_cnt_reg   <= left_cnt_next;
            right_cnt_reg  <= right_cnt_next;
        end
    end

endmodule

[sv/ghdc_out_stage.sv]
// ----------------------------------------------------------------------------
// Gyro heading duty corrector result stage
// Holds one packed result until the master side takes it.
// ----------------------------------------------------------------------------
module ghdc_out_stage #(
    parameter int DUTY_BITS = ghdc_pkg::DUTY_BITS_DEF,
    parameter int M_DATA_W  = ((2 * DUTY_BITS + 1 + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ghdc_pkg::stage_ctrl_t ctrl,
    input  logic [DUTY_BITS-1:0]  left_duty_out,
    input  logic [DUTY_BITS-1:0]  right_duty_out,
    input  logic                  moving,
    output logic                  take,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_DATA_W-1:0]   m_axis_tdata
);

    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg;

    // Room for a new result when empty or being taken
    assign take = !valid_reg || m_axis_tready;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.fire)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    // Pack the result, left duty lowest
    always_ff @(posedge clk)
    begin
        if (ctrl.fire)
            data_reg <= M_DATA_W'({moving, right_duty_out, left_duty_out});
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

[sv/gyro_heading_duty_corrector.sv]
// ----------------------------------------------------------------------------
// Gyro heading duty corrector
// Two-motor duty drive with gyro-based heading correction on straight-run ticks.
// ----------------------------------------------------------------------------
// Path: the input stage registers a request, the result stage its result.
// Throughput: one request per cycle unless stalled; the input register and the
// result register each hold one request, so the input stalls only when both
// are full.
// Reset: rst_n clears the motion state to idle with zero duties and counts,
// sets the turn threshold to 100 and empties both stages.
module gyro_heading_duty_corrector #(
    parameter int DUTY_BITS  = ghdc_pkg::DUTY_BITS_DEF,
    parameter int COUNT_BITS = ghdc_pkg::COUNT_BITS_DEF,
    parameter int TICK_MS    = ghdc_pkg::TICK_MS_DEF,
    parameter int S_DATA_W   = ((ghdc_pkg::GYRO_W + DUTY_BITS + ghdc_pkg::TIME_W + 7) / 8) * 8,
    parameter int M_DATA_W   = ((2 * DUTY_BITS + 1 + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ghdc_pkg::THR_W-1:0]  cfg_data,       // turn_threshold
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [S_DATA_W-1:0]         s_axis_tdata,   // gyro_z, base_duty, run_time_ms
    input  logic [ghdc_pkg::FUNC_W-1:0] s_axis_tuser,   // func
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [M_DATA_W-1:0]         m_axis_tdata    // left_duty_out, right_duty_out, moving
);

    ghdc_pkg::stage_ctrl_t              ctrl;
    logic                               take;
    logic [ghdc_pkg::FUNC_W-1:0]        func;
    logic signed [ghdc_pkg::GYRO_W-1:0] gyro_z;
    logic [DUTY_BITS-1:0]               base_duty;
    logic [ghdc_pkg::TIME_W-1:0]        run_time_ms;
    logic [DUTY_BITS-1:0]               left_duty_out;
    logic [DUTY_BITS-1:0]               right_duty_out;
    logic                               moving;

    // Threshold writes are always taken
    assign cfg_ready = 1'b1;

    ghdc_in_stage #(
        .DUTY_BITS (DUTY_BITS),
        .S_DATA_W  (S_DATA_W)
    ) u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (take),
        .ctrl          (ctrl),
        .func          (func),
        .gyro_z        (gyro_z),
        .base_duty     (base_duty),
        .run_time_ms   (run_time_ms)
    );

    ghdc_core #(
        .DUTY_BITS  (DUTY_BITS),
        .COUNT_BITS (COUNT_BITS),
        .TICK_MS    (TICK_MS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .ctrl           (ctrl),
        .func           (func),
        .gyro_z         (gyro_z),
        .base_duty      (base_duty),
        .run_time_ms    (run_time_ms),
        .left_duty_out  (left_duty_out),
        .right_duty_out (right_duty_out),
        .moving         (moving)
    );

    ghdc_out_stage #(
        .DUTY_BITS (DUTY_BITS),
        .M_DATA_W  (M_DATA_W)
    ) u_out_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .left_duty_out  (left_duty_out),
        .right_duty_out (right_duty_out),
        .moving         (moving),
        .take           (take),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

endmodule

[sv/ghdc_checker.sv]
// ----------------------------------------------------------------------------
// Gyro heading duty corrector port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module ghdc_checker #(
    parameter int DUTY_BITS = ghdc_pkg::DUTY_BITS_DEF,
    parameter int S_DATA_W  = ((ghdc_pkg::GYRO_W + DUTY_BITS + ghdc_pkg::TIME_W + 7) / 8) * 8,
    parameter int M_DATA_W  = ((2 * DUTY_BITS + 1 + 7) / 8) * 8
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [ghdc_pkg::THR_W-1:0]  cfg_data,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [S_DATA_W-1:0]         s_axis_tdata,
    input logic [ghdc_pkg::FUNC_W-1:0] s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [M_DATA_W-1:0]         m_axis_tdata
);

    localparam int MOVE_BIT = 2 * DUTY_BITS;

    logic [DUTY_BITS-1:0] left_seen;
    logic [DUTY_BITS-1:0] right_seen;
    logic                 moving_seen;

    assign left_seen   = m_axis_tdata[DUTY_BITS-1:0];
    assign right_seen  = m_axis_tdata[DUTY_BITS +: DUTY_BITS];
    assign moving_seen = m_axis_tdata[MOVE_BIT];

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Input stalls only when both stages are full and the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked result");

    // An idle result drives both motors at zero
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !moving_seen |-> left_seen == '0 && right_seen == '0)
        else $error("idle result with non-zero duty");

    // Threshold writes are never refused
    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("threshold write refused");

endmodule

bind gyro_heading_duty_corrector ghdc_checker #(
    .DUTY_BITS (DUTY_BITS),
    .S_DATA_W  (S_DATA_W),
    .M_DATA_W  (M_DATA_W)
) u_ghdc_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro heading duty corrector testbench
// Drives start, stop, tick and gyro sample requests into the corrector over
// its stream port and writes the turn threshold between phases. Each accepted
// request is run through a local model of the duty and heading state, and
// every result is checked field by field against it or, for typed directed
// rows, against the row. A short table of directed requests comes first. Then
// come random straight runs, spins and noise under several thresholds, with
// random gaps on both sides, a long receiver stall and one calm stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DUTY_W   = ghdc_pkg::DUTY_BITS_DEF;
    localparam int CNT_W    = ghdc_pkg::COUNT_BITS_DEF;
    localparam int TICK_LEN = ghdc_pkg::TICK_MS_DEF;
    localparam int GZ_W     = ghdc_pkg::GYRO_W;
    localparam int TM_W     = ghdc_pkg::TIME_W;
    localparam int FN_W     = ghdc_pkg::FUNC_W;
    localparam int TH_W     = ghdc_pkg::THR_W;
    localparam int S_W      = ((GZ_W + DUTY_W + TM_W + 7) / 8) * 8;
    localparam int M_W      = ((2 * DUTY_W + 1 + 7) / 8) * 8;
    localparam int PAD_W    = S_W - GZ_W - DUTY_W - TM_W;
    localparam int DUTY_MAX = (1 << DUTY_W) - 1;
    localparam int CNT_MAX  = (1 << CNT_W) - 1;
    localparam int PHASE_ITEMS = 180;

    // One result as it leaves the block
    typedef struct packed {
        logic              moving;
        logic [DUTY_W-1:0] right;
        logic [DUTY_W-1:0] left;
    } duty_result_t;

    // One row of the directed table
    typedef struct packed {
        logic [FN_W-1:0]   fn;
        logic [GZ_W-1:0]   gz;
        logic [DUTY_W-1:0] base;
        logic [TM_W-1:0]   rt;
        logic              typed;
        duty_result_t      want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [TH_W-1:0]    cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [S_W-1:0]     s_axis_tdata;   // gyro_z, base_duty, run_time_ms
    logic [FN_W-1:0]    s_axis_tuser;   // func
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [M_W-1:0]     m_axis_tdata;   // left_duty_out, right_duty_out, moving

    // Model state
    logic [TH_W-1:0]    thr_m;
    logic [DUTY_W-1:0]  lduty_m;
    logic [DUTY_W-1:0]  rduty_m;
    logic [TM_W-1:0]    tleft_m;
    ghdc_pkg::mode_t    mode_m;
    logic [CNT_W-1:0]   lcnt_m;
    logic [CNT_W-1:0]   rcnt_m;

    duty_result_t       pending_duties[$];
    stim_row_t          directed_rows[$];
    int                 fail_count;
    int                 useful_count;
    bit                 calm;
    bit                 hold_req;
    int                 stall_left;

    gyro_heading_duty_corrector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Drop the movement and clear duties, time and counts
    function automatic void clear_motion();
        mode_m  = ghdc_pkg::MODE_IDLE;
        lduty_m = '0;
        rduty_m = '0;
        tleft_m = '0;
        lcnt_m  = '0;
        rcnt_m  = '0;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_raise(input logic [DUTY_W-1:0] d, input int s);
        int sum;
        sum = int'(d) + s;
        return (sum > DUTY_MAX) ? DUTY_W'(DUTY_MAX) : DUTY_W'(sum);
    endfunction

    function automatic logic [DUTY_W-1:0] duty_lower(input logic [DUTY_W-1:0] d, input int s);
        return (int'(d) > s) ? DUTY_W'(int'(d) - s) : '0;
    endfunction

    // Advance the heading state by one request and return the duties it shows
    function automatic duty_result_t advance_heading(input logic [FN_W-1:0] fn,
                                                     input logic [GZ_W-1:0] gz_raw,
                                                     input logic [DUTY_W-1:0] base,
                                                     input logic [TM_W-1:0] rt);
        int gz;
        int lim;
        int diff;
        int step;
        duty_result_t res;
        gz  = $signed(gz_raw);
        lim = int'(thr_m);
        case (fn)
            ghdc_pkg::FUNC_SAMPLE:
            begin
                if (mode_m == ghdc_pkg::MODE_STRAIGHT)
                begin
                    if (gz > lim)
                    begin
                        if (rcnt_m != CNT_W'(CNT_MAX))
                            rcnt_m = rcnt_m + 1'b1;
                    end
                    else if (gz < -lim)
                    begin
                        if (lcnt_m != CNT_W'(CNT_MAX))
                            lcnt_m = lcnt_m + 1'b1;
                    end
                end
            end
            ghdc_pkg::FUNC_TICK:
            begin
                if (mode_m != ghdc_pkg::MODE_IDLE)
                begin
                    if (tleft_m == '0 || tleft_m > TM_W'(TICK_LEN))
                    begin
                        if (tleft_m != '0)
                            tleft_m = tleft_m - TM_W'(TICK_LEN);
                        if (mode_m == ghdc_pkg::MODE_STRAIGHT)
                        begin
                            // Pick the step from the count difference
                            diff = (lcnt_m >= rcnt_m) ? int'(lcnt_m) - int'(rcnt_m)
                                                      : int'(rcnt_m) - int'(lcnt_m);
                            if (diff > 25)
                                step = 200;
                            else if (diff > 20)
                                step = 100;
                            else if (diff > 15)
                                step = 50;
                            else if (diff > 10)
                                step = 20;
                            else
                                step = 5;
                            // Shift the duties toward the slower side
                            if (lcnt_m > rcnt_m)
                            begin
                                lduty_m = duty_raise(lduty_m, step);
                                rduty_m = duty_lower(rduty_m, step);
                            end
                            else if (lcnt_m < rcnt_m)
                            begin
                                lduty_m = duty_lower(lduty_m, step);
                                rduty_m = duty_raise(rduty_m, step);
                            end
                            lcnt_m = '0;
                            rcnt_m = '0;
                        end
                    end
                    else
                        clear_motion();
                end
            end
            ghdc_pkg::FUNC_STRAIGHT, ghdc_pkg::FUNC_CW, ghdc_pkg::FUNC_ACW:
            begin
                mode_m  = (fn == ghdc_pkg::FUNC_STRAIGHT) ? ghdc_pkg::MODE_STRAIGHT :
                          (fn == ghdc_pkg::FUNC_CW) ? ghdc_pkg::MODE_CW : ghdc_pkg::MODE_ACW;
                lduty_m = base;
                rduty_m = base;
                tleft_m = rt;
                lcnt_m  = '0;
                rcnt_m  = '0;
            end
            ghdc_pkg::FUNC_STOP:
                clear_motion();
            default:
                ;
        endcase
        res.left   = (mode_m == ghdc_pkg::MODE_STRAIGHT || mode_m == ghdc_pkg::MODE_CW) ?
                     lduty_m : '0;
        res.right  = (mode_m == ghdc_pkg::MODE_STRAIGHT || mode_m == ghdc_pkg::MODE_ACW) ?
                     rduty_m : '0;
        res.moving = (mode_m != ghdc_pkg::MODE_IDLE);
        return res;
    endfunction

    function automatic stim_row_t mk_row(input logic [FN_W-1:0] fn, input int gz,
                                         input int base, input logic [TM_W-1:0] rt,
                                         input bit typed, input int l, input int r,
                                         input bit mv);
        stim_row_t row;
        row.fn          = fn;
        row.gz          = GZ_W'(gz);
        row.base        = DUTY_W'(base);
        row.rt          = rt;
        row.typed       = typed;
        row.want.left   = DUTY_W'(l);
        row.want.right  = DUTY_W'(r);
        row.want.moving = mv;
        return row;
    endfunction

    // Gyro sample around the threshold, leaning one way most of the time
    function automatic logic [GZ_W-1:0] rand_gyro(input bit lean_right);
        int r;
        int mag;
        bit dir;
        r = $urandom_range(99);
        if (r < 10)
            return GZ_W'(lean_right ? int'(thr_m) : -int'(thr_m));
        if (r < 25)
            return GZ_W'($urandom);
        mag = int'(thr_m) + 1 + $urandom_range(0, 300);
        if (mag > 32767)
            mag = 32767;
        dir = ($urandom_range(99) < 80) ? lean_right : !lean_right;
        return GZ_W'(dir ? mag : -mag);
    endfunction

    function automatic logic [TM_W-1:0] pick_run_time();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return '0;
        if (r < 80)
            return TM_W'(TICK_LEN * $urandom_range(1, 10) + $urandom_range(0, TICK_LEN - 1));
        return TM_W'($urandom);
    endfunction

    // Offer one request, hold it until accepted, then log its expected result
    task automatic send_request(input logic [FN_W-1:0] fn, input logic [GZ_W-1:0] gz,
                                input logic [DUTY_W-1:0] base, input logic [TM_W-1:0] rt,
                                input bit typed, input duty_result_t want);
        duty_result_t res;
        bit ignored;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {{PAD_W{1'b0}}, rt, base, gz};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ignored = (fn == ghdc_pkg::FUNC_SAMPLE && mode_m != ghdc_pkg::MODE_STRAIGHT) ||
                  (fn == ghdc_pkg::FUNC_TICK && mode_m == ghdc_pkg::MODE_IDLE) ||
                  (fn > ghdc_pkg::FUNC_STOP);
        if (!ignored)
            useful_count++;
        res = advance_heading(fn, gz, base, rt);
        pending_duties.push_back(typed ? want : res);
    endtask

    // Stop offering, then hold until every expected result is back
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [TH_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        thr_m = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random straight runs, spins and noise until enough requests mattered
    task automatic run_phase(input int target);
        int kind;
        int windows;
        int samples;
        int stop_at;
        bit lean;
        logic [FN_W-1:0] fn;
        stop_at = useful_count + target;
        while (useful_count < stop_at)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                // Straight run: sample windows closed by ticks
                send_request(ghdc_pkg::FUNC_STRAIGHT, GZ_W'($urandom), DUTY_W'($urandom),
                             pick_run_time(), 1'b0, '0);
                windows = $urandom_range(1, 8);
                repeat (windows)
                begin
                    lean    = $urandom_range(1);
                    samples = $urandom_range(0, 40);
                    repeat (samples)
                    begin
                        if ($urandom_range(99) < 3)
                            fn = FN_W'($urandom_range(ghdc_pkg::FUNC_STOP + 1, 7));
                        else
                            fn = ghdc_pkg::FUNC_SAMPLE;
                        send_request(fn, rand_gyro(lean), DUTY_W'($urandom),
                                     TM_W'($urandom), 1'b0, '0);
                    end
                    send_request(ghdc_pkg::FUNC_TICK, GZ_W'($urandom), DUTY_W'($urandom),
                                 TM_W'($urandom), 1'b0, '0);
                end
                if ($urandom_range(99) < 30)
                    send_request(ghdc_pkg::FUNC_STOP, GZ_W'($urandom), DUTY_W'($urandom),
                                 TM_W'($urandom), 1'b0, '0);
            end
            else if (kind < 85)
            begin
                // Spin: a few samples and ticks that only count time down
                fn = $urandom_range(1) ? ghdc_pkg::FUNC_CW : ghdc_pkg::FUNC_ACW;
                send_request(fn, GZ_W'($urandom), DUTY_W'($urandom),
                             pick_run_time(), 1'b0, '0);
                repeat ($urandom_range(1, 6))
                begin
                    fn = $urandom_range(1) ? ghdc_pkg::FUNC_TICK : ghdc_pkg::FUNC_SAMPLE;
                    send_request(fn, rand_gyro($urandom_range(1)), DUTY_W'($urandom),
                                 TM_W'($urandom), 1'b0, '0);
                end
            end
            else
            begin
                // Noise: any code with any fields
                repeat ($urandom_range(1, 5))
                    send_request(FN_W'($urandom_range(0, 7)), GZ_W'($urandom),
                                 DUTY_W'($urandom), TM_W'($urandom), 1'b0, '0);
            end
        end
    endtask

    // Result receiver: random back-pressure, long stall on request
    initial
    begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = 64;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (calm)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 27);
        end
    end

    // Result checker
    always @(posedge clk)
    begin : duty_check
        duty_result_t got;
        duty_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.left   = m_axis_tdata[DUTY_W-1:0];
            got.right  = m_axis_tdata[2*DUTY_W-1:DUTY_W];
            got.moving = m_axis_tdata[2*DUTY_W];
            if (pending_duties.size() == 0)
            begin
                $error("unexpected result: left %0d right %0d moving %0d",
                       got.left, got.right, got.moving);
                fail_count++;
            end
            else
            begin
                want = pending_duties.pop_front();
                if (got.left !== want.left)
                begin
                    $error("left_duty_out mismatch: expected %0d, got %0d", want.left, got.left);
                    fail_count++;
                end
                if (got.right !== want.right)
                begin
                    $error("right_duty_out mismatch: expected %0d, got %0d",
                           want.right, got.right);
                    fail_count++;
                end
                if (got.moving !== want.moving)
                begin
                    $error("moving mismatch: expected %0d, got %0d", want.moving, got.moving);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        fail_count    = 0;
        useful_count  = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        thr_m         = ghdc_pkg::THR_RESET;
        clear_motion();

        // Directed table, reset threshold of 100
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_TICK, 0, 0, 0, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_SAMPLE, 32767, 0, 0, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(3'd6, -1, DUTY_MAX, 32'hFFFF_FFFF, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(3'd7, 0, 0, 0, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_STRAIGHT, 0, DUTY_MAX, 0, 1,
                                       DUTY_MAX, DUTY_MAX, 1));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_SAMPLE, -32768, 0, 0, 1,
                                       DUTY_MAX, DUTY_MAX, 1));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_STRAIGHT, 0, 0, 80, 1, 0, 0, 1));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_SAMPLE, 101, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_SAMPLE, 100, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_SAMPLE, -100, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_TICK, 0, 0, 0, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_CW, 0, 1234, 0, 1, 1234, 0, 1));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_SAMPLE, -1000, 0, 0, 1, 1234, 0, 1));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_TICK, 0, 0, 0, 1, 1234, 0, 1));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_ACW, 0, 4321, 41, 1, 0, 4321, 1));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_TICK, 0, 0, 0, 1, 0, 4321, 1));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_TICK, 0, 0, 0, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_STRAIGHT, 0, 4096, 32'hFFFF_FFFF, 1,
                                       4096, 4096, 1));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_STOP, 0, 0, 0, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(ghdc_pkg::FUNC_STOP, 0, 0, 0, 1, 0, 0, 0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].fn, directed_rows[i].gz, directed_rows[i].base,
                         directed_rows[i].rt, directed_rows[i].typed, directed_rows[i].want);

        // Drive one count into saturation with a zero threshold
        write_threshold('0);
        send_request(ghdc_pkg::FUNC_STRAIGHT, '0, DUTY_W'(4000), '0, 1'b0, '0);
        repeat (CNT_MAX + 8)
            send_request(ghdc_pkg::FUNC_SAMPLE, GZ_W'($urandom_range(1, 32767)), '0, '0,
                         1'b0, '0);
        send_request(ghdc_pkg::FUNC_TICK, '0, '0, '0, 1'b0, '0);
        send_request(ghdc_pkg::FUNC_STOP, '0, '0, '0, 1'b0, '0);

        // Random phases across thresholds; stall the receiver, then run calm
        write_threshold(TH_W'($urandom_range(1, 32766)));
        run_phase(PHASE_ITEMS);
        write_threshold('1);
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS);
        write_threshold(TH_W'($urandom_range(1, 300)));
        calm = 1'b1;
        run_phase(PHASE_ITEMS);
        calm = 1'b0;
        write_threshold('0);
        run_phase(PHASE_ITEMS);
        write_threshold(ghdc_pkg::THR_RESET);
        run_phase(PHASE_ITEMS);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
